@@ design/lpr_pkg.sv @@
// Shared constants, types and state codes for the LRU page replacement block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package lpr_pkg;

   localparam int FRAMES     = 16;
   localparam int PAGE_BITS  = 16;
   localparam int CFG_BITS   = 5;
   localparam int FAULT_BITS = 32;

   localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_BITS = SLOT_BITS;
   localparam int FILL_BITS = $clog2(FRAMES + 1);
   localparam int N_BITS    = (CFG_BITS > FILL_BITS) ? CFG_BITS : FILL_BITS;
   localparam int FRAMES_P2 = 1 << SLOT_BITS;
   localparam int LEVELS    = SLOT_BITS;

   localparam logic [CFG_BITS-1:0]  CFG_RESET = CFG_BITS'(16);
   localparam logic [RANK_BITS-1:0] RANK_MAX  = RANK_BITS'(FRAMES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lpr_state_type;

   typedef struct packed {
      logic load_page;
      logic lookup;
      logic update;
   } lpr_cmd_type;

   typedef struct packed {
      logic out_free;
   } lpr_status_type;

   typedef struct packed {
      logic                 vld;
      logic [RANK_BITS-1:0] rank;
      logic [SLOT_BITS-1:0] idx;
   } lpr_cand_type;

endpackage

`default_nettype wire

@@ design/lpr_channel_if.sv @@
// Request and response channel interfaces with valid/ready handshakes.
// Depends on lpr_pkg for the payload widths.
`default_nettype none

interface lpr_req_if;
   logic                           valid;
   logic                           ready;
   logic [lpr_pkg::PAGE_BITS-1:0]  page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lpr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           hit;
   logic [lpr_pkg::SLOT_BITS-1:0]  slot;
   logic                           evicted_valid;
   logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page;
   logic [lpr_pkg::FAULT_BITS-1:0] fault_count;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output fault_count, input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

@@ design/lpr_ctrl.sv @@
// Sequencing state machine: accept, lookup, update.
// Depends on lpr_pkg and the request channel interface.
`default_nettype none

module lpr_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   lpr_req_if.sink                      req,
   output lpr_pkg::lpr_cmd_type         cmd,
   input  wire lpr_pkg::lpr_status_type status
);

   lpr_pkg::lpr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req.ready     = 1'b0;
      unique case (state_ff)
         lpr_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.load_page = 1'b1;
               state_in      = lpr_pkg::ST_LOOKUP;
            end
         end
         lpr_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = lpr_pkg::ST_UPDATE;
         end
         lpr_pkg::ST_UPDATE: begin
            // The update retires only once the result register can take it.
            if (status.out_free) begin
               cmd.update = 1'b1;
               req.ready  = 1'b1;
               if (req.valid) begin
                  cmd.load_page = 1'b1;
                  state_in      = lpr_pkg::ST_LOOKUP;
               end else begin
                  state_in = lpr_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lpr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/lpr_datapath.sv @@
// Frame table, recency ranks, search trees, fault counter and result register.
// Depends on lpr_pkg and the response channel interface.
`default_nettype none

module lpr_datapath (
   input  wire                             clock,
   input  wire                             reset,
   input  wire lpr_pkg::lpr_cmd_type       cmd,
   output lpr_pkg::lpr_status_type         status,
   input  wire [lpr_pkg::PAGE_BITS-1:0]    page_number,
   input  wire                             csr_write_enable,
   input  wire [lpr_pkg::CFG_BITS-1:0]     csr_write_data,
   lpr_rsp_if.source                       rsp
);

   // Architectural state.
   logic [lpr_pkg::PAGE_BITS-1:0]  page_ff, page_in;
   logic [lpr_pkg::PAGE_BITS-1:0]  resident_ff [lpr_pkg::FRAMES];
   logic [lpr_pkg::PAGE_BITS-1:0]  resident_in [lpr_pkg::FRAMES];
   logic [lpr_pkg::FRAMES-1:0]     valid_ff, valid_in;
   logic [lpr_pkg::RANK_BITS-1:0]  rank_ff [lpr_pkg::FRAMES];
   logic [lpr_pkg::RANK_BITS-1:0]  rank_in [lpr_pkg::FRAMES];
   logic [lpr_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [lpr_pkg::FAULT_BITS-1:0] faults_ff, faults_in;
   logic [lpr_pkg::CFG_BITS-1:0]   frames_ff, frames_in;

   // Lookup decision, held from the lookup to the update.
   logic                           hit_ff, hit_in;
   logic                           use_fill_ff, use_fill_in;
   logic                           have_victim_ff, have_victim_in;
   logic                           limit_all_ff, limit_all_in;
   logic [lpr_pkg::SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [lpr_pkg::RANK_BITS-1:0]  limit_ff, limit_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   logic [lpr_pkg::SLOT_BITS-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                           rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [lpr_pkg::PAGE_BITS-1:0]  rsp_ev_page_ff, rsp_ev_page_in;
   logic [lpr_pkg::FAULT_BITS-1:0] rsp_faults_ff, rsp_faults_in;

   logic [lpr_pkg::N_BITS-1:0]     n_eff;
   logic [lpr_pkg::FRAMES-1:0]     active;
   logic                           fill_room;
   lpr_pkg::lpr_cand_type          hit_node [lpr_pkg::LEVELS+1][lpr_pkg::FRAMES_P2];
   lpr_pkg::lpr_cand_type          vic_node [lpr_pkg::LEVELS+1][lpr_pkg::FRAMES_P2];
   lpr_pkg::lpr_cand_type          hit_root, vic_root;
   logic                           rank_inc;

   assign status.out_free = !rsp_valid_ff || rsp.ready;

   // Active frame count, clamped to one through FRAMES.
   always_comb begin
      if (frames_ff == '0) begin
         n_eff = lpr_pkg::N_BITS'(1);
      end else if (lpr_pkg::N_BITS'(frames_ff) > lpr_pkg::N_BITS'(lpr_pkg::FRAMES)) begin
         n_eff = lpr_pkg::N_BITS'(lpr_pkg::FRAMES);
      end else begin
         n_eff = lpr_pkg::N_BITS'(frames_ff);
      end
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
         active[i] = lpr_pkg::N_BITS'(i) < n_eff;
      end
      fill_room = lpr_pkg::N_BITS'(fill_ff) < n_eff;
   end

   // Two binary trees: the lowest matching frame, and the oldest valid frame
   // with ties going to the lower slot.
   always_comb begin
      for (int l = 0; l <= lpr_pkg::LEVELS; l++) begin
         for (int k = 0; k < lpr_pkg::FRAMES_P2; k++) begin
            hit_node[l][k] = '0;
            vic_node[l][k] = '0;
         end
      end
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
         hit_node[0][i].vld  = valid_ff[i] && active[i] && (resident_ff[i] == page_ff);
         hit_node[0][i].rank = rank_ff[i];
         hit_node[0][i].idx  = lpr_pkg::SLOT_BITS'(i);
         vic_node[0][i].vld  = valid_ff[i] && active[i];
         vic_node[0][i].rank = rank_ff[i];
         vic_node[0][i].idx  = lpr_pkg::SLOT_BITS'(i);
      end
      for (int l = 0; l < lpr_pkg::LEVELS; l++) begin
         for (int k = 0; k < (lpr_pkg::FRAMES_P2 >> (l + 1)); k++) begin
            hit_node[l+1][k] = hit_node[l][2*k].vld ? hit_node[l][2*k] : hit_node[l][2*k+1];
            if (vic_node[l][2*k].vld &&
                (!vic_node[l][2*k+1].vld ||
                 vic_node[l][2*k].rank >= vic_node[l][2*k+1].rank)) begin
               vic_node[l+1][k] = vic_node[l][2*k];
            end else begin
               vic_node[l+1][k] = vic_node[l][2*k+1];
            end
         end
      end
      hit_root = hit_node[lpr_pkg::LEVELS][0];
      vic_root = vic_node[lpr_pkg::LEVELS][0];
   end

   always_comb begin
      page_in        = page_ff;
      frames_in      = frames_ff;
      hit_in         = hit_ff;
      use_fill_in    = use_fill_ff;
      have_victim_in = have_victim_ff;
      limit_all_in   = limit_all_ff;
      slot_in        = slot_ff;
      limit_in       = limit_ff;
      valid_in       = valid_ff;
      fill_in        = fill_ff;
      faults_in      = faults_ff;
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
         resident_in[i] = resident_ff[i];
         rank_in[i]     = rank_ff[i];
      end
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_faults_in   = rsp_faults_ff;
      rank_inc        = 1'b0;

      if (csr_write_enable) begin
         frames_in = csr_write_data;
      end

      if (cmd.load_page) begin
         page_in = page_number;
      end

      if (cmd.lookup) begin
         hit_in         = hit_root.vld;
         use_fill_in    = !hit_root.vld && fill_room;
         have_victim_in = !hit_root.vld && !fill_room && vic_root.vld;
         limit_all_in   = !hit_root.vld && (fill_room || !vic_root.vld);
         limit_in       = hit_root.vld ? hit_root.rank : vic_root.rank;
         if (hit_root.vld) begin
            slot_in = hit_root.idx;
         end else if (fill_room) begin
            slot_in = lpr_pkg::SLOT_BITS'(fill_ff);
         end else if (vic_root.vld) begin
            slot_in = vic_root.idx;
         end else begin
            slot_in = '0;
         end
      end

      if (cmd.update) begin
         // Age the frames that were younger than the touched one, then make
         // the touched frame the most recent.
         for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
            rank_inc = active[i] && valid_ff[i] &&
                       (lpr_pkg::SLOT_BITS'(i) != slot_ff) &&
                       (limit_all_ff || (rank_ff[i] < limit_ff)) &&
                       (rank_ff[i] != lpr_pkg::RANK_MAX);
            if (lpr_pkg::SLOT_BITS'(i) == slot_ff) begin
               rank_in[i] = '0;
            end else if (rank_inc) begin
               rank_in[i] = rank_ff[i] + lpr_pkg::RANK_BITS'(1);
            end
         end
         if (!hit_ff) begin
            valid_in[slot_ff]    = 1'b1;
            resident_in[slot_ff] = page_ff;
            if (faults_ff != '1) begin
               faults_in = faults_ff + lpr_pkg::FAULT_BITS'(1);
            end
            if (use_fill_ff) begin
               fill_in = fill_ff + lpr_pkg::FILL_BITS'(1);
            end
         end
         rsp_valid_in    = 1'b1;
         rsp_hit_in      = hit_ff;
         rsp_slot_in     = slot_ff;
         rsp_ev_valid_in = have_victim_ff;
         rsp_ev_page_in  = have_victim_ff ? resident_ff[slot_ff] : '0;
         rsp_faults_in   = faults_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_ff      <= '0;
         faults_ff    <= '0;
         frames_ff    <= lpr_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         faults_ff    <= faults_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff         <= page_in;
      hit_ff          <= hit_in;
      use_fill_ff     <= use_fill_in;
      have_victim_ff  <= have_victim_in;
      limit_all_ff    <= limit_all_in;
      slot_ff         <= slot_in;
      limit_ff        <= limit_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_faults_ff   <= rsp_faults_in;
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
         resident_ff[i] <= resident_in[i];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = rsp_hit_ff;
   assign rsp.slot          = rsp_slot_ff;
   assign rsp.evicted_valid = rsp_ev_valid_ff;
   assign rsp.evicted_page  = rsp_ev_page_ff;
   assign rsp.fault_count   = rsp_faults_ff;

endmodule

`default_nettype wire

@@ design/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: controller plus datapath.
// Depends on lpr_pkg, lpr_channel_if, lpr_ctrl and lpr_datapath.
//
//   channel   direction  handshake            payload
//   req_bus   in         valid / ready        page_number[15:0]
//   rsp_bus   out        valid / ready        hit, slot[3:0], evicted_valid,
//                                             evicted_page[15:0], fault_count[31:0]
//   csr_*     in         write enable only    frames_in_use[4:0]
//
// Each request passes through a lookup state, which compares the page against
// every frame tag and runs the hit and oldest-frame trees over the registered
// state, and an update state, which applies the rank aging, writes the frame
// and loads the result register. A new request is taken in the update state.
// A result that waits in the output register holds the update cycle, and with
// it the request side. Reset is synchronous and needs no clearing pass.
`default_nettype none

module lru_page_replacement (
   input  wire                          clock,
   input  wire                          reset,
   lpr_req_if.sink                      req_bus,
   lpr_rsp_if.source                    rsp_bus,
   input  wire                          csr_write_enable,
   input  wire [lpr_pkg::CFG_BITS-1:0]  csr_write_data
);

   // Commands from the sequencer and status back from the datapath.
   lpr_pkg::lpr_cmd_type    cmd;
   lpr_pkg::lpr_status_type status;

   // The controller owns the request handshake and steps every request
   // through lookup and update.
   lpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .cmd    (cmd),
      .status (status)
   );

   // The datapath holds the frames, ranks, counters and the result register.
   lpr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .page_number      (req_bus.page_number),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   // A latched request is always looked up in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_page |=> cmd.lookup)
      else $error("latched request was not looked up");

   // Every update presents a result on the response channel.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_bus.valid)
      else $error("update did not produce a result");

   // No request is taken while a lookup is in flight.
   assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |-> !req_bus.ready)
      else $error("request accepted during lookup");
`endif

endmodule

`default_nettype wire

@@ tb/tb_lru_page_replacement.sv @@
// Self-checking testbench for the LRU page replacement block.
// Depends on lpr_pkg, the lpr_req_if / lpr_rsp_if channel interfaces and the
// lru_page_replacement top level; it predicts every response in-line.
`timescale 1ns / 1ps

module tb_lru_page_replacement;

   localparam int RESET_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 105;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int HOLDOFF_ITEMS  = 30;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PRINT_LIMIT    = 40;

   // One predicted response, laid out like the response channel payload.
   typedef struct packed {
      logic                           hit;
      logic [lpr_pkg::SLOT_BITS-1:0]  slot;
      logic                           evicted_valid;
      logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page;
      logic [lpr_pkg::FAULT_BITS-1:0] fault_count;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [lpr_pkg::CFG_BITS-1:0] csr_write_data;

   lpr_req_if req_bus ();
   lpr_rsp_if rsp_bus ();

   lru_page_replacement DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor copy of the frame table and the one configuration register.
   logic [lpr_pkg::PAGE_BITS-1:0]  frame_tag  [lpr_pkg::FRAMES];
   logic                           frame_live [lpr_pkg::FRAMES];
   logic [lpr_pkg::RANK_BITS-1:0]  frame_age  [lpr_pkg::FRAMES];
   logic [lpr_pkg::FILL_BITS-1:0]  frames_filled;
   logic [lpr_pkg::FAULT_BITS-1:0] fault_tally;
   logic [lpr_pkg::CFG_BITS-1:0]   frames_cfg;

   outcome_type pending_outcomes [$];

   int  mismatch_count;
   int  rsp_index;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  holdoff_request;
   logic holding;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int frames_active();
      if (frames_cfg == 0)
         return 1;
      else if (frames_cfg > lpr_pkg::FRAMES)
         return lpr_pkg::FRAMES;
      else
         return int'(frames_cfg);
   endfunction

   // Age every active resident frame younger than the limit, then make the
   // target frame the most recent one.
   function automatic void age_frames(input int n, input int target,
                                      input int unsigned limit);
      for (int i = 0; i < n; i++) begin
         if (i != target && frame_live[i] && frame_age[i] < limit &&
             frame_age[i] < lpr_pkg::RANK_MAX)
            frame_age[i] = frame_age[i] + 1'b1;
      end
      frame_age[target] = '0;
   endfunction

   // Looks one page up in the predicted frame table, applies the hit, fill or
   // replacement and returns the response the block must give.
   function automatic outcome_type compute_outcome(
      input logic [lpr_pkg::PAGE_BITS-1:0] page);
      outcome_type res;
      int n;
      int slot;
      bit found;
      bit have;
      logic [lpr_pkg::RANK_BITS-1:0] best;
      res   = '0;
      n     = frames_active();
      slot  = 0;
      found = 1'b0;
      have  = 1'b0;
      best  = '0;
      // A page resident twice answers from the lowest slot.
      for (int i = 0; i < n; i++) begin
         if (!found && frame_live[i] && frame_tag[i] == page) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         age_frames(n, slot, frame_age[slot]);
      end else begin
         if (fault_tally != '1)
            fault_tally = fault_tally + 1'b1;
         if (frames_filled < n) begin
            slot = int'(frames_filled);
            frames_filled = frames_filled + 1'b1;
            frame_tag[slot]  = page;
            frame_live[slot] = 1'b1;
            age_frames(n, slot, 32'hFFFF_FFFF);
         end else begin
            // Strictly greater keeps the lowest slot among equal ranks.
            for (int i = 0; i < n; i++) begin
               if (frame_live[i] && (!have || frame_age[i] > best)) begin
                  best = frame_age[i];
                  slot = i;
                  have = 1'b1;
               end
            end
            if (have) begin
               res.evicted_valid = 1'b1;
               res.evicted_page  = frame_tag[slot];
            end
            frame_tag[slot]  = page;
            frame_live[slot] = 1'b1;
            age_frames(n, slot, have ? int'(best) : 32'hFFFF_FFFF);
         end
      end
      res.hit         = found;
      res.slot        = lpr_pkg::SLOT_BITS'(slot);
      res.fault_count = fault_tally;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at response %0d: %s got %0h expected %0h",
                  rsp_index, what, got, want);
      mismatch_count++;
   endtask

   // Offers one request, with a random gap first, and records the predicted
   // response once the request is taken. The valid stays high on return.
   task automatic send_page(input logic [lpr_pkg::PAGE_BITS-1:0] page);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_bus.valid       <= 1'b1;
      req_bus.page_number <= page;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      pending_outcomes.push_back(compute_outcome(page));
   endtask

   // Stops offering requests and waits until every response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_frames(input logic [lpr_pkg::CFG_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frames_cfg = value;
   endtask

   // Lowering and raising the frame count: a page left resident twice, equal
   // ranks among the candidates, a zero count and a count above the frames.
   task automatic test_frame_count_changes();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_frames(lpr_pkg::CFG_BITS'(2));
      send_page(16'h1234);
      send_page(16'h8421);
      send_page(16'h8421);
      drain_responses();
      // Zero acts as one frame: the only candidate is slot 0.
      write_frames(lpr_pkg::CFG_BITS'(0));
      send_page(16'h8421);
      drain_responses();
      write_frames(lpr_pkg::CFG_BITS'(2));
      send_page(16'h8421);
      send_page(16'h5A5A);
      send_page(16'h8421);
      drain_responses();
      // Above the frame count saturates; the free slots are filled first.
      write_frames(lpr_pkg::CFG_BITS'(31));
      send_page(16'hC3C3);
      drain_responses();
   endtask

   task automatic test_page_extremes();
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'hFFFF);
      send_page(16'h0000);
      drain_responses();
      write_frames(lpr_pkg::CFG_BITS'(5));
      send_page(16'h7FFF);
      send_page(16'h8000);
      drain_responses();
   endtask

   // Phases of pool-based traffic so that hits, fills and evictions mix,
   // with a little fully random noise, under every idling pattern.
   task automatic test_random_traffic();
      logic [lpr_pkg::CFG_BITS-1:0]  settings [10];
      logic [lpr_pkg::PAGE_BITS-1:0] pool [$];
      logic [lpr_pkg::PAGE_BITS-1:0] page;
      logic [lpr_pkg::PAGE_BITS-1:0] last_page;
      int pool_size;
      int pick;
      int n;
      settings = '{5'd1, 5'd3, 5'd0, 5'd7, 5'd12, 5'd17, 5'd31, 5'd16, 5'd2, 5'd16};
      for (int ph = 0; ph < 10; ph++) begin
         write_frames(settings[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         n = frames_active();
         pool_size = n + $urandom_range(0, n / 2 + 2);
         pool.delete();
         repeat (pool_size) pool.push_back(lpr_pkg::PAGE_BITS'($urandom));
         last_page = pool[0];
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               page = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 88)
               page = last_page;
            else
               page = lpr_pkg::PAGE_BITS'($urandom);
            send_page(page);
            last_page = page;
         end
         drain_responses();
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the block fills and must stall its request side.
   task automatic test_output_holdoff();
      logic [lpr_pkg::PAGE_BITS-1:0] pool [8];
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 8; i++)
         pool[i] = lpr_pkg::PAGE_BITS'($urandom);
      holdoff_request = 1'b1;
      repeat (HOLDOFF_ITEMS) send_page(pool[$urandom_range(0, 7)]);
      drain_responses();
   endtask

   initial begin : rsp_holdoff
      holding = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            holding <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holding <= 1'b0;
         end
      end
   end

   initial begin : rsp_sink
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holding)
            rsp_bus.ready <= 1'b0;
         else
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with none pending", 32'd0, 32'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.hit !== want.hit)
               report_mismatch("hit", 32'(rsp_bus.hit), 32'(want.hit));
            if (rsp_bus.slot !== want.slot)
               report_mismatch("slot", 32'(rsp_bus.slot), 32'(want.slot));
            if (rsp_bus.evicted_valid !== want.evicted_valid)
               report_mismatch("evicted_valid", 32'(rsp_bus.evicted_valid),
                               32'(want.evicted_valid));
            if (rsp_bus.evicted_page !== want.evicted_page)
               report_mismatch("evicted_page", 32'(rsp_bus.evicted_page),
                               32'(want.evicted_page));
            if (rsp_bus.fault_count !== want.fault_count)
               report_mismatch("fault_count", rsp_bus.fault_count,
                               want.fault_count);
         end
         rsp_index++;
      end
   end

   // Ends the run when neither channel moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.page_number = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      mismatch_count      = 0;
      rsp_index           = 0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      holdoff_request     = 1'b0;
      for (int i = 0; i < lpr_pkg::FRAMES; i++) begin
         frame_tag[i]  = '0;
         frame_live[i] = 1'b0;
         frame_age[i]  = '0;
      end
      frames_filled = '0;
      fault_tally   = '0;
      frames_cfg    = lpr_pkg::CFG_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_frame_count_changes();
      test_page_extremes();
      test_random_traffic();
      test_output_holdoff();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
